// ===== design/longest_window_with_target_sum_core_macros.svh =====
// Assertion helpers shared by the window block.
`ifndef LONGEST_WINDOW_WITH_TARGET_SUM_CORE_MACROS_SVH
`define LONGEST_WINDOW_WITH_TARGET_SUM_CORE_MACROS_SVH

// Condition must hold at every edge outside reset.
`define LWTS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("lwts invariant violated");

// Antecedent implies consequent in the same cycle.
`define LWTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lwts implication violated");

`endif

// ===== design/lwts_pkg.sv =====
package lwts_pkg;

  localparam int MAX_LEN     = 1024;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int ELEM_W      = 16;
  localparam int TARGET_W    = 26;
  localparam int SUM_W       = TARGET_W + 1;
  localparam int LEN_W       = 11;
  localparam int OUT_TDATA_W = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  // One classified element on its way from the front to the back.
  typedef struct packed {
    logic [ELEM_W-1:0] element;
    logic              last;
    logic              keep;  // store has room for this element
  } item_t;

endpackage

// ===== design/lwts_front.sv =====
module lwts_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [lwts_pkg::ELEM_W-1:0]  in_tdata,
  input  logic                         in_tlast,
  input  logic                         fifo_full,
  output logic                         push,
  output lwts_pkg::item_t              push_item
);
  import lwts_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             keep;

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && in_tready;
  assign keep      = cnt_r < CNT_W'(MAX_LEN);

  assign push_item.element = in_tdata;
  assign push_item.last    = in_tlast;
  assign push_item.keep    = keep;

  // Count elements of the current array; saturate once the store is full.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push) begin
      if (in_tlast) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/lwts_fifo.sv =====
module lwts_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lwts_pkg::item_t push_item,
  input  logic            pop,
  output lwts_pkg::item_t head,
  output logic            full,
  output logic            empty
);
  import lwts_pkg::*;

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW:0]   wr_ptr_r;
  logic [FIFO_AW:0]   rd_ptr_r;

  assign empty = wr_ptr_r == rd_ptr_r;
  assign full  = (wr_ptr_r[FIFO_AW] != rd_ptr_r[FIFO_AW]) &&
                 (wr_ptr_r[FIFO_AW-1:0] == rd_ptr_r[FIFO_AW-1:0]);
  assign head  = mem_r[rd_ptr_r[FIFO_AW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[FIFO_AW-1:0]] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + (FIFO_AW+1)'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + (FIFO_AW+1)'(1);
      end
    end
  end

endmodule

// ===== design/lwts_back.sv =====
`include "longest_window_with_target_sum_core_macros.svh"

module lwts_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [lwts_pkg::TARGET_W-1:0]    target,
  input  logic                             empty,
  input  lwts_pkg::item_t                  head,
  output logic                             pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lwts_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser
);
  import lwts_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SUB,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    start_r, start_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    best_r, best_nxt;
  logic                ovf_r, ovf_nxt;
  logic                last_r, last_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;
  logic                out_ovf_r, out_ovf_nxt;

  logic [ELEM_W-1:0]   win_mem [MAX_LEN];
  logic [ELEM_W-1:0]   rd_data_r;
  logic                wr_en;
  logic                rd_en;
  logic                shrink;
  logic [CNT_W-1:0]    win_len;

  assign shrink  = (sum_r > SUM_W'(target)) && (start_r < count_r);
  assign win_len = count_r - start_r;
  assign pop     = (state_r == S_IDLE) && !empty;
  assign wr_en   = pop && head.keep;
  assign rd_en   = (state_r == S_CHECK) && shrink;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_len_r);
  assign out_tuser  = out_ovf_r;

  // Window store: append at the count; read the front in the check state into a register for the subtract state.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[count_r[ADDR_W-1:0]] <= head.element;
    end
    if (rd_en) begin
      rd_data_r <= win_mem[start_r[ADDR_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    start_nxt     = start_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (!empty) begin
          last_nxt = head.last;
          if (head.keep) begin
            count_nxt = count_r + CNT_W'(1);
            sum_nxt   = sum_r + SUM_W'(head.element);
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (shrink) begin
          state_nxt = S_SUB;
        end else begin
          if ((sum_r == SUM_W'(target)) && (win_len > best_r)) begin
            best_nxt = win_len;
          end
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_SUB: begin
        // drop the front element
        sum_nxt   = sum_r - SUM_W'(rd_data_r);
        start_nxt = start_r + CNT_W'(1);
        state_nxt = S_CHECK;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = LEN_W'(best_r);
          out_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          start_nxt     = '0;
          sum_nxt       = '0;
          best_nxt      = '0;
          ovf_nxt       = 1'b0;
          last_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= '0;
      sum_r       <= '0;
      best_r      <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_len_r   <= '0;
      out_ovf_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      sum_r       <= sum_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      out_len_r   <= out_len_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  `LWTS_ASSERT_ALWAYS(a_start_le_count, clk, rst_n, start_r <= count_r)
  `LWTS_ASSERT_ALWAYS(a_best_le_count, clk, rst_n, best_r <= count_r)
  `LWTS_ASSERT_IMP(a_sub_nonempty, clk, rst_n, state_r == S_SUB, start_r < count_r)
  `LWTS_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(MAX_LEN))

endmodule

// ===== design/longest_window_with_target_sum_core.sv =====
// Longest window with target sum, two-pointer sliding window.
// in_*  : one array element per beat; in_tdata = element[15:0], in_tlast marks
//         the final element of the array.
// out_* : one beat per array, on its last element; out_tdata[10:0] holds the
//         longest length (0 if no window matched), out_tuser is set when the
//         array ran past 1024 elements and was truncated.
// cfg_* : cfg_wr_en writes target_sum from cfg_wr_data; write only while idle.
// A front stage classifies each beat (stored or beyond the store) and pushes it
// into a four-entry queue; the back stage appends to the window store, then
// drops front elements while the sum exceeds the target, each drop passing a
// check and a subtract state since the store read is registered.
// Each element passes the idle and check states in the back, plus a subtract
// and a check per dropped element; every element is dropped at most once. The
// back finishes one element before it pops the next; out_tvalid is set from the
// emit state once the last beat's checks and drops are done.
// Reset clears all counters, the target and the queue.
// While out_tready is low the result register holds; the queue keeps taking
// beats until it fills, after which in_tready drops.
module longest_window_with_target_sum_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lwts_pkg::ELEM_W-1:0]      in_tdata,   // element[15:0]
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lwts_pkg::OUT_TDATA_W-1:0] out_tdata,  // longest_length[10:0], zeros
  output logic                             out_tuser,  // overflowed
  input  logic                             cfg_wr_en,
  input  logic [lwts_pkg::TARGET_W-1:0]    cfg_wr_data
);
  import lwts_pkg::*;

  logic [TARGET_W-1:0] target_r;
  logic                push;
  item_t               push_item;
  logic                pop;
  item_t               head;
  logic                full;
  logic                empty;

  // Hold the target; the back compares against it every check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr_en) begin
      target_r <= cfg_wr_data;
    end
  end

  lwts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .fifo_full (full),
    .push      (push),
    .push_item (push_item)
  );

  lwts_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  lwts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .target     (target_r),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== tb/sv/tb_longest_window_with_target_sum_core.sv =====
module tb_longest_window_with_target_sum_core;
  import lwts_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 600000;
  // Idle time before a target write: covers a beat still in flight with its drops.
  localparam int CFG_SETTLE   = 32;
  localparam int TAIL_CYCLES  = 50;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_BEATS = 520;
  localparam int PHASE_BEATS  = 220;

  localparam logic [TARGET_W-1:0] TARGET_MAX  = '1;
  // 1024 beats of 0xFFFF sum to exactly this, so a full store matches end to end.
  localparam logic [TARGET_W-1:0] TARGET_FULL = TARGET_W'(MAX_LEN * 65535);

  // Receiver backpressure styles.
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

  // Target families; the zero, small and scaled ones steer element values so windows actually match.
  typedef enum int {TGT_ZERO, TGT_SMALL, TGT_SCALED, TGT_WIDE, TGT_MAX} target_kind_t;

  // One expected result beat.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflowed;
  } window_result_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [ELEM_W-1:0]      in_tdata    = '0;   // element[15:0]
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;          // longest_length[10:0], zeros
  logic                   out_tuser;          // overflowed
  logic                   cfg_wr_en   = 1'b0;
  logic [TARGET_W-1:0]    cfg_wr_data = '0;

  longest_window_with_target_sum_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Window predictor: mirrors the two-pointer scan with its own state copy.
  // ---------------------------------------------------------------------------
  logic [ELEM_W-1:0]   win_mem [MAX_LEN];
  int unsigned         fill_count  = 0;
  int unsigned         front_idx   = 0;
  longint unsigned     win_sum     = 0;
  int unsigned         best_len    = 0;
  bit                  trunc_seen  = 1'b0;
  logic [TARGET_W-1:0] target_q    = '0;

  window_result_t      pending_results [$];
  int unsigned         mismatch_count = 0;
  int unsigned         beats_sent     = 0;
  int unsigned         cycle_count    = 0;

  // Sender and receiver controls; the receiver writes hold_served and rx_tick, the test thread the rest.
  int                  tx_gap_max    = 0;
  int                  burst_left    = 0;
  rx_mode_t            rx_mode       = RX_ALWAYS;
  int unsigned         hold_requests = 0;
  int unsigned         hold_served   = 0;
  int unsigned         rx_tick       = 0;
  int unsigned         tgt_unit      = 1;
  logic [ELEM_W-1:0]   array_buf [$];

  // Advance the predictor by one accepted beat; queue a result on the last one.
  function automatic void window_predict(logic [ELEM_W-1:0] elem, bit last);
    int unsigned    span;
    window_result_t res;
    if (fill_count < MAX_LEN) begin
      win_mem[fill_count] = elem;
      fill_count++;
      win_sum += elem;
      // Drop from the front while the window overshoots, never past the newest beat.
      while (win_sum > target_q && front_idx < fill_count) begin
        win_sum -= win_mem[front_idx];
        front_idx++;
      end
      if (win_sum == target_q) begin
        span = fill_count - front_idx;
        if (span > best_len)
          best_len = span;
      end
    end else begin
      // Store is full: ignore the element but remember the truncation.
      trunc_seen = 1'b1;
    end
    if (last) begin
      res.length     = LEN_W'(best_len);
      res.overflowed = trunc_seen;
      pending_results.push_back(res);
      fill_count = 0;
      front_idx  = 0;
      win_sum    = 0;
      best_len   = 0;
      trunc_seen = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted output beat with the oldest entry.
  // ---------------------------------------------------------------------------
  window_result_t seen_front;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none pending, expected none, actual len %0d ovf %0b",
                 $time, out_tdata[LEN_W-1:0], out_tuser);
        mismatch_count++;
      end else begin
        seen_front = pending_results.pop_front();
        if (out_tdata[LEN_W-1:0] !== seen_front.length) begin
          $display("%0t: longest_length expected %0d actual %0d",
                   $time, seen_front.length, out_tdata[LEN_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[OUT_TDATA_W-1:LEN_W] !== '0) begin
          $display("%0t: tdata pad bits expected 0 actual 'h%0h",
                   $time, out_tdata[OUT_TDATA_W-1:LEN_W]);
          mismatch_count++;
        end
        if (out_tuser !== seen_front.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b",
                   $time, seen_front.overflowed, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if the block wedges.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drive out_tready on the falling edge. A long hold-off request holds
  // ready low for a span set by LONG_HOLD and counted here, so the queue fills.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_served != hold_requests) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_served++;
      end else begin
        case (rx_mode)
          RX_ALWAYS:  out_tready <= 1'b1;
          RX_RANDOM:  out_tready <= ($urandom_range(0, 2) != 0);
          RX_PATTERN: out_tready <= ((rx_tick % 5) < 2);
          default:    out_tready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one beat on the falling edge and hold it until the block takes it.
  // Insert a random gap when gaps are enabled and the current burst runs out.
  task automatic send_element(logic [ELEM_W-1:0] elem, bit last);
    int gap;
    if (tx_gap_max > 0 && burst_left == 0) begin
      gap        = $urandom_range(1, tx_gap_max);
      burst_left = $urandom_range(1, 12);
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= elem;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    window_predict(elem, last);
  endtask

  // Send the buffered array, marking its final element with tlast.
  task automatic send_buffered_array();
    foreach (array_buf[i])
      send_element(array_buf[i], i == array_buf.size() - 1);
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_results_done();
    @(negedge clk) in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the target only once the block has gone quiet.
  task automatic write_target(logic [TARGET_W-1:0] value);
    wait_results_done();
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk) cfg_wr_en <= 1'b0;
    target_q = value;
  endtask

  // Pick a target for the family; scaled targets share a unit with the elements.
  function automatic logic [TARGET_W-1:0] pick_target(target_kind_t kind);
    case (kind)
      TGT_ZERO:   return '0;
      TGT_SMALL:  return TARGET_W'($urandom_range(1, 64));
      TGT_SCALED: begin
        tgt_unit = $urandom_range(1, 4000);
        return TARGET_W'(tgt_unit * $urandom_range(2, 16));
      end
      TGT_WIDE:   return TARGET_W'($urandom_range(0, 32'h03FF_FFFF));
      default:    return TARGET_MAX;
    endcase
  endfunction

  // Mostly well-shaped values for the target family, with full-range noise.
  function automatic logic [ELEM_W-1:0] pick_element(target_kind_t kind);
    if ($urandom_range(0, 15) == 0)
      return ELEM_W'($urandom_range(0, 65535));
    case (kind)
      TGT_ZERO:   return ($urandom_range(0, 3) == 0) ? ELEM_W'($urandom_range(1, 5)) : '0;
      TGT_SMALL:  return ($urandom_range(0, 3) == 0) ? '0 : ELEM_W'($urandom_range(1, 16));
      TGT_SCALED: return ELEM_W'(tgt_unit * $urandom_range(0, 4));
      default:    return ELEM_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_array(target_kind_t kind, int len);
    array_buf.delete();
    repeat (len) array_buf.push_back(pick_element(kind));
    send_buffered_array();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset target of zero: zero runs extend a match, nonzero beats empty the window.
  task automatic test_zero_target();
    rx_mode    = RX_RANDOM;
    tx_gap_max = 3;
    array_buf = '{16'h0000, 16'h0000, 16'h0000};
    send_buffered_array();
    array_buf = '{16'h0007, 16'h0000, 16'h0000, 16'h0009};
    send_buffered_array();
    array_buf = '{16'h0003};
    send_buffered_array();
  endtask

  // Field extremes, alternating bit patterns, the widest target and a window
  // that empties completely before it matches.
  task automatic test_field_extremes();
    write_target(TARGET_W'(16'hFFFF));
    array_buf = '{16'hFFFF};
    send_buffered_array();
    array_buf = '{16'hAAAA, 16'h5555};
    send_buffered_array();
    write_target(TARGET_MAX);
    array_buf = '{16'hFFFF, 16'h0000};
    send_buffered_array();
    write_target(TARGET_W'(9));
    array_buf = '{16'd20, 16'd4, 16'd5, 16'd0};
    send_buffered_array();
  endtask

  // Hold the receiver off while the sender keeps offering, so the queue fills and
  // in_tready drops; then pause the sender until everything has drained and send more arrays to a patterned receiver.
  task automatic test_output_backpressure();
    write_target(TARGET_W'(30));
    rx_mode    = RX_ALWAYS;
    tx_gap_max = 0;
    hold_requests++;
    repeat (14) send_random_array(TGT_SMALL, $urandom_range(1, 6));
    wait_results_done();
    rx_mode = RX_PATTERN;
    repeat (4) send_random_array(TGT_SMALL, $urandom_range(1, 6));
  endtask

  // Random phases: each sets a target family and idle style, then streams arrays.
  task automatic test_random_arrays();
    int unsigned  start_beats;
    int unsigned  phase_start;
    int           len;
    target_kind_t kind;
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      kind = target_kind_t'($urandom_range(0, 4));
      write_target(pick_target(kind));
      rx_mode    = rx_mode_t'($urandom_range(0, 2));
      tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 10);
      phase_start = beats_sent;
      while (beats_sent - phase_start < PHASE_BEATS &&
             beats_sent - start_beats < RANDOM_BEATS) begin
        // Mostly short arrays, a few long ones.
        len = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
        send_random_array(kind, len);
        if ($urandom_range(0, 9) == 0)
          wait_results_done();
      end
    end
  endtask

  // Store full: run past MAX_LEN with the end mark on an ignored beat, so the
  // kept part matches end to end; then check the next array starts clean.
  task automatic test_store_full();
    rx_mode    = RX_RANDOM;
    tx_gap_max = 4;
    write_target(TARGET_FULL);
    array_buf.delete();
    repeat (MAX_LEN + 6) array_buf.push_back(16'hFFFF);
    send_buffered_array();
    write_target(TARGET_W'(40));
    array_buf = '{16'd40};
    send_buffered_array();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_zero_target();
    test_field_extremes();
    test_output_backpressure();
    test_random_arrays();
    test_store_full();

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/lwts_pkg.sv
design/lwts_front.sv
design/lwts_fifo.sv
design/lwts_back.sv
design/longest_window_with_target_sum_core.sv
tb/sv/tb_longest_window_with_target_sum_core.sv
